@@ src/etrb_pkg.sv @@
// Shared constants and the record type of the event trace ring buffer.
package etrb_pkg;

    localparam int CAPACITY    = 32;
    localparam int MAX_RESULTS = 32;

    localparam int PTR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int TOT_W   = 6;
    localparam int WANT_W  = 6;
    localparam int CMP_W   = (CNT_W > TOT_W) ? CNT_W : TOT_W;
    localparam int SUM_W   = PTR_W + 2;

    localparam logic [1:0] CMD_RECORD   = 2'd0;
    localparam logic [1:0] CMD_SNAPSHOT = 2'd1;
    localparam logic [1:0] CMD_CLEAR    = 2'd2;

    typedef struct packed {
        logic [31:0] timestamp;
        logic [15:0] event_code;
        logic [15:0] small_argument;
        logic [31:0] first_word;
        logic [31:0] second_word;
    } record_t;

endpackage

@@ src/etrb_store.sv @@
// Record storage: one write port and one registered read port.
module etrb_store (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [etrb_pkg::PTR_W-1:0] wr_addr,
    input  etrb_pkg::record_t          wr_data,
    input  logic                       rd_en,
    input  logic [etrb_pkg::PTR_W-1:0] rd_addr,
    output etrb_pkg::record_t          rd_data
);
    import etrb_pkg::*;

    record_t mem_reg [CAPACITY];
    record_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rdata_reg;

endmodule

@@ src/event_trace_ring_buffer_unit.sv @@
// Event trace ring buffer. A record transaction is written into the store and the block is
// ready again on the next cycle; a clear likewise leaves the block ready. A snapshot walks
// the store through its single read port: each returned record passes through a store read
// (ST_READ) and then the presentation of the result (ST_OUT), held while the consumer holds
// ready low. An empty snapshot presents its single result on the cycle after acceptance.
// Input is not taken while a snapshot is being delivered. Records come out oldest first,
// and is_last marks the final one.
module event_trace_ring_buffer_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  cmd,
    input  logic [31:0]                 timestamp,
    input  logic [15:0]                 event_code,
    input  logic [15:0]                 small_argument,
    input  logic [31:0]                 first_word,
    input  logic [31:0]                 second_word,
    input  logic [etrb_pkg::WANT_W-1:0] max_wanted,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        has_record,
    output logic [etrb_pkg::TOT_W-1:0]  copied_total,
    output logic                        is_last,
    output logic [31:0]                 out_timestamp,
    output logic [15:0]                 out_event,
    output logic [15:0]                 out_small_argument,
    output logic [31:0]                 out_first_word,
    output logic [31:0]                 out_second_word
);
    import etrb_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] rd_idx_reg, rd_idx_next;
    logic [TOT_W-1:0] remain_reg, remain_next;
    logic [TOT_W-1:0] total_reg, total_next;
    logic             has_rec_reg, has_rec_next;
    logic             last_reg, last_next;

    logic             in_fire;
    logic             out_fire;
    logic [CMP_W-1:0] count_ext;
    logic [CMP_W-1:0] want_ext;
    logic [CMP_W-1:0] n_a;
    logic [CMP_W-1:0] n_b;
    logic [TOT_W-1:0] n_sel;
    logic [SUM_W-1:0] start_sum;
    logic [PTR_W-1:0] start_idx;
    logic             wr_en;
    logic             rd_en;
    record_t          wr_rec;
    record_t          rd_rec;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid && out_ready;

    // Number of records a snapshot returns: min(fill count, request, result limit).
    always_comb
    begin
        count_ext = CMP_W'(count_reg);
        want_ext  = CMP_W'(max_wanted);
        n_a       = (count_ext < want_ext) ? count_ext : want_ext;
        n_b       = (n_a < CMP_W'(MAX_RESULTS)) ? n_a : CMP_W'(MAX_RESULTS);
        n_sel     = n_b[TOT_W-1:0];
    end

    // Oldest returned entry sits n places behind the write pointer.
    always_comb
    begin
        start_sum = SUM_W'(wp_reg) + SUM_W'(CAPACITY) - SUM_W'(n_sel);
        if (start_sum >= SUM_W'(CAPACITY))
        begin
            start_sum = start_sum - SUM_W'(CAPACITY);
        end
        start_idx = start_sum[PTR_W-1:0];
    end

    assign wr_en  = in_fire && (cmd == CMD_RECORD);
    assign rd_en  = (state_reg == ST_READ);
    assign wr_rec = '{timestamp:      timestamp,
                      event_code:     event_code,
                      small_argument: small_argument,
                      first_word:     first_word,
                      second_word:    second_word};

    etrb_store u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wp_reg),
        .wr_data (wr_rec),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg),
        .rd_data (rd_rec)
    );

    always_comb
    begin
        state_next   = state_reg;
        wp_next      = wp_reg;
        count_next   = count_reg;
        rd_idx_next  = rd_idx_reg;
        remain_next  = remain_reg;
        total_next   = total_reg;
        has_rec_next = has_rec_reg;
        last_next    = last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    priority if (cmd == CMD_RECORD)
                    begin
                        wp_next = (wp_reg == PTR_W'(CAPACITY - 1)) ? '0 : wp_reg + 1'b1;
                        if (count_reg != CNT_W'(CAPACITY))
                        begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else if (cmd == CMD_CLEAR)
                    begin
                        wp_next    = '0;
                        count_next = '0;
                    end
                    else if (cmd == CMD_SNAPSHOT)
                    begin
                        total_next = n_sel;
                        if (n_sel == '0)
                        begin
                            has_rec_next = 1'b0;
                            last_next    = 1'b1;
                            state_next   = ST_OUT;
                        end
                        else
                        begin
                            has_rec_next = 1'b1;
                            remain_next  = n_sel;
                            rd_idx_next  = start_idx;
                            state_next   = ST_READ;
                        end
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_READ:
            begin
                last_next   = (remain_reg == TOT_W'(1));
                remain_next = remain_reg - 1'b1;
                rd_idx_next = (rd_idx_reg == PTR_W'(CAPACITY - 1)) ? '0 : rd_idx_reg + 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_fire)
                begin
                    state_next = last_reg ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            wp_reg      <= '0;
            count_reg   <= '0;
            remain_reg  <= '0;
            has_rec_reg <= 1'b0;
            last_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            wp_reg      <= wp_next;
            count_reg   <= count_next;
            remain_reg  <= remain_next;
            has_rec_reg <= has_rec_next;
            last_reg    <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= rd_idx_next;
        total_reg  <= total_next;
    end

    assign has_record         = has_rec_reg;
    assign copied_total       = total_reg;
    assign is_last            = last_reg;
    assign out_timestamp      = has_rec_reg ? rd_rec.timestamp      : '0;
    assign out_event          = has_rec_reg ? rd_rec.event_code     : '0;
    assign out_small_argument = has_rec_reg ? rd_rec.small_argument : '0;
    assign out_first_word     = has_rec_reg ? rd_rec.first_word     : '0;
    assign out_second_word    = has_rec_reg ? rd_rec.second_word    : '0;

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("fill count exceeds capacity");

    a_snapshot_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && cmd == CMD_SNAPSHOT) |=> !in_ready)
        else $error("block ready right after accepting a snapshot");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !has_record) |-> (is_last && copied_total == '0))
        else $error("empty snapshot result malformed");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && is_last) |=> in_ready)
        else $error("block not idle after final snapshot result");

    a_more_after: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && !is_last) |=> (!in_ready && remain_reg != '0))
        else $error("snapshot ended before its last result");

endmodule

@@ sim/tb_event_trace_ring_buffer_unit.sv @@
// Self-checking testbench for the event trace ring buffer: directed table, random phases, predictor.
`timescale 1ns / 100ps

module tb_event_trace_ring_buffer_unit;

    import etrb_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int RANDOM_PER_PHASE = 78;
    localparam int END_SETTLE       = 2 * MAX_RESULTS + 10;
    localparam int CYCLE_LIMIT      = 400000;

    localparam record_t REC_ZERO    = '0;
    localparam record_t REC_ONES    = '1;
    localparam record_t REC_ALT     = {32'hA5A5_5A5A, 16'h5A5A, 16'hA5A5,
                                       32'h0F0F_F0F0, 32'h1234_5678};
    localparam record_t REC_ALT_INV = ~REC_ALT;

    typedef struct packed {
        logic [1:0]        cmd;
        record_t           rec;
        logic [WANT_W-1:0] max_wanted;
    } trace_cmd_t;

    typedef struct packed {
        logic             has_record;
        logic [TOT_W-1:0] copied_total;
        logic             is_last;
        record_t          rec;
    } trace_result_t;

    typedef struct packed {
        trace_cmd_t    item;
        logic          typed;
        trace_result_t fixed_res;
    } table_row_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [1:0]          cmd;
    logic [31:0]         timestamp;
    logic [15:0]         event_code;
    logic [15:0]         small_argument;
    logic [31:0]         first_word;
    logic [31:0]         second_word;
    logic [WANT_W-1:0]   max_wanted;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic                has_record;
    logic [TOT_W-1:0]    copied_total;
    logic                is_last;
    logic [31:0]         out_timestamp;
    logic [15:0]         out_event;
    logic [15:0]         out_small_argument;
    logic [31:0]         out_first_word;
    logic [31:0]         out_second_word;

    // Typed rows of the table carry their own expectation alongside the payload.
    logic                row_typed;
    trace_result_t       row_result;

    int                  idle_pct;
    int                  stall_pct;
    int                  mismatches = 0;
    int                  cycle_count = 0;

    // Predictor state of the trace store.
    record_t             trace_store [CAPACITY];
    int                  write_slot = 0;
    int                  stored_count = 0;
    trace_result_t       expected_results [$];
    table_row_t          directed_rows [$];

    event_trace_ring_buffer_unit dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .cmd                (cmd),
        .timestamp          (timestamp),
        .event_code         (event_code),
        .small_argument     (small_argument),
        .first_word         (first_word),
        .second_word        (second_word),
        .max_wanted         (max_wanted),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .has_record         (has_record),
        .copied_total       (copied_total),
        .is_last            (is_last),
        .out_timestamp      (out_timestamp),
        .out_event          (out_event),
        .out_small_argument (out_small_argument),
        .out_first_word     (out_first_word),
        .out_second_word    (out_second_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL event_trace_ring_buffer_unit");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Applies one accepted transaction to the trace store and queues its results.
    function automatic void predict_trace(input trace_cmd_t it);
        int            take;
        int            first_slot;
        trace_result_t res;
        case (it.cmd)
            CMD_RECORD:
            begin
                trace_store[write_slot] = it.rec;
                write_slot = (write_slot + 1) % CAPACITY;
                if (stored_count < CAPACITY)
                    stored_count++;
            end
            CMD_CLEAR:
            begin
                write_slot   = 0;
                stored_count = 0;
            end
            CMD_SNAPSHOT:
            begin
                take = stored_count;
                if (take > int'(it.max_wanted))
                    take = int'(it.max_wanted);
                if (take > MAX_RESULTS)
                    take = MAX_RESULTS;
                if (take == 0)
                begin
                    res = '0;
                    res.is_last = 1'b1;
                    expected_results.push_back(res);
                end
                else
                begin
                    first_slot = (write_slot + CAPACITY - take) % CAPACITY;
                    for (int i = 0; i < take; i++)
                    begin
                        res.has_record   = 1'b1;
                        res.copied_total = take[TOT_W-1:0];
                        res.is_last      = (i == take - 1);
                        res.rec          = trace_store[(first_slot + i) % CAPACITY];
                        expected_results.push_back(res);
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    // Input acceptance is handled before the output check so a same-edge pair stays ordered.
    always @(posedge clk)
    begin
        trace_cmd_t    seen;
        trace_result_t want;
        if (in_valid && in_ready)
        begin
            seen.cmd        = cmd;
            seen.rec        = {timestamp, event_code, small_argument, first_word, second_word};
            seen.max_wanted = max_wanted;
            // Typed rows are all snapshots, which leave the store unchanged.
            if (row_typed)
                expected_results.push_back(row_result);
            else
                predict_trace(seen);
        end
        if (out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with no transaction pending, expected none, actual %0h",
                         $time, {has_record, copied_total, is_last, out_event});
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("has_record", 32'(want.has_record), 32'(has_record));
                check_field("copied_total", 32'(want.copied_total), 32'(copied_total));
                check_field("is_last", 32'(want.is_last), 32'(is_last));
                check_field("out_timestamp", want.rec.timestamp, out_timestamp);
                check_field("out_event", 32'(want.rec.event_code), 32'(out_event));
                check_field("out_small_argument", 32'(want.rec.small_argument),
                            32'(out_small_argument));
                check_field("out_first_word", want.rec.first_word, out_first_word);
                check_field("out_second_word", want.rec.second_word, out_second_word);
            end
        end
    end

    function automatic table_row_t table_row(input logic [1:0] c, input record_t rec,
                                             input logic [WANT_W-1:0] want, input logic typed,
                                             input trace_result_t fixed);
        table_row_t row;
        row.item.cmd        = c;
        row.item.rec        = rec;
        row.item.max_wanted = want;
        row.typed           = typed;
        row.fixed_res       = fixed;
        return row;
    endfunction

    function automatic trace_cmd_t random_item();
        trace_cmd_t it;
        int         pick;
        pick = $urandom_range(99);
        if (pick < 62)
            it.cmd = CMD_RECORD;
        else if (pick < 92)
            it.cmd = CMD_SNAPSHOT;
        else if (pick < 94)
            it.cmd = CMD_CLEAR;
        else
            it.cmd = CMD_UNUSED;
        it.rec = {$urandom, $urandom, $urandom, $urandom};
        case ($urandom_range(3))
            0:       it.max_wanted = WANT_W'($urandom_range(0, 63));
            1:       it.max_wanted = WANT_W'($urandom_range(28, 40));
            default: it.max_wanted = WANT_W'($urandom_range(1, 6));
        endcase
        return it;
    endfunction

    task automatic send_item(input trace_cmd_t it, input logic typed,
                             input trace_result_t fixed);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        cmd            <= it.cmd;
        timestamp      <= it.rec.timestamp;
        event_code     <= it.rec.event_code;
        small_argument <= it.rec.small_argument;
        first_word     <= it.rec.first_word;
        second_word    <= it.rec.second_word;
        max_wanted     <= it.max_wanted;
        row_typed      <= typed;
        row_result     <= fixed;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Holds the sender off until every queued result has been delivered.
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        trace_cmd_t it;
        int         sent;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        cmd            = CMD_RECORD;
        timestamp      = '0;
        event_code     = '0;
        small_argument = '0;
        first_word     = '0;
        second_word    = '0;
        max_wanted     = '0;
        row_typed      = 1'b0;
        row_result     = '0;
        idle_pct       = 0;
        stall_pct      = 0;

        // Empty snapshots come back as one result with no record and is_last set.
        directed_rows.push_back(table_row(CMD_SNAPSHOT, REC_ZERO, 6'd1, 1'b1,
                                          {1'b0, 6'd0, 1'b1, REC_ZERO}));
        directed_rows.push_back(table_row(CMD_RECORD, REC_ZERO, 6'd0, 1'b0, '0));
        directed_rows.push_back(table_row(CMD_SNAPSHOT, REC_ONES, 6'd0, 1'b1,
                                          {1'b0, 6'd0, 1'b1, REC_ZERO}));
        directed_rows.push_back(table_row(CMD_SNAPSHOT, REC_ONES, 6'd1, 1'b1,
                                          {1'b1, 6'd1, 1'b1, REC_ZERO}));
        directed_rows.push_back(table_row(CMD_RECORD, REC_ONES, 6'h3F, 1'b0, '0));
        directed_rows.push_back(table_row(CMD_SNAPSHOT, REC_ZERO, 6'd1, 1'b1,
                                          {1'b1, 6'd1, 1'b1, REC_ONES}));
        directed_rows.push_back(table_row(CMD_UNUSED, REC_ALT, 6'd63, 1'b0, '0));
        directed_rows.push_back(table_row(CMD_RECORD, REC_ALT, 6'd21, 1'b0, '0));
        directed_rows.push_back(table_row(CMD_RECORD, REC_ALT_INV, 6'd42, 1'b0, '0));
        directed_rows.push_back(table_row(CMD_SNAPSHOT, REC_ALT, 6'd63, 1'b0, '0));
        directed_rows.push_back(table_row(CMD_SNAPSHOT, REC_ALT_INV, 6'd2, 1'b0, '0));
        directed_rows.push_back(table_row(CMD_SNAPSHOT, REC_ZERO, 6'd4, 1'b0, '0));
        directed_rows.push_back(table_row(CMD_CLEAR, REC_ONES, 6'h3F, 1'b0, '0));
        directed_rows.push_back(table_row(CMD_SNAPSHOT, REC_ZERO, 6'd32, 1'b1,
                                          {1'b0, 6'd0, 1'b1, REC_ZERO}));
        directed_rows.push_back(table_row(CMD_RECORD, REC_ALT, 6'd0, 1'b0, '0));
        directed_rows.push_back(table_row(CMD_SNAPSHOT, REC_ONES, 6'd32, 1'b0, '0));
        directed_rows.push_back(table_row(CMD_CLEAR, REC_ZERO, 6'd0, 1'b0, '0));
        directed_rows.push_back(table_row(CMD_SNAPSHOT, REC_ONES, 6'd63, 1'b1,
                                          {1'b0, 6'd0, 1'b1, REC_ZERO}));

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].typed,
                      directed_rows[i].fixed_res);

        for (int phase = 0; phase < 4; phase++)
        begin
            drain_results();
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 67; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 67; end
                default: begin idle_pct = 15; stall_pct = 15; end
            endcase
            sent = 0;
            while (sent < RANDOM_PER_PHASE)
            begin
                it = random_item();
                send_item(it, 1'b0, '0);
                if (it.cmd != CMD_UNUSED)
                    sent++;
            end
        end

        drain_results();
        repeat (END_SETTLE) @(posedge clk);
        if (mismatches == 0)
            $display("PASS event_trace_ring_buffer_unit");
        else
            $display("FAIL event_trace_ring_buffer_unit");
        $finish;
    end

endmodule
